// ===== sv/trapezoid_ramp_profile_core_assert.svh =====
// Assertion macros for the trapezoid ramp profile core.
// Pulled in by the port checker; depends on nothing else.
`ifndef TRAPEZOID_RAMP_PROFILE_CORE_ASSERT_SVH
`define TRAPEZOID_RAMP_PROFILE_CORE_ASSERT_SVH
// same-cycle implication, reset masked
`define TRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// implication after a fixed delay, reset masked
`define TRP_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error(msg);
`endif

// ===== sv/trp_pkg.sv =====
// Types, pipeline stage map and per-stage datapath for the trapezoid ramp profile core.
// No dependencies; used by the core and by its port checker.
`default_nettype none

package trp_pkg;

  typedef struct packed {
    logic [31:0] axis0_steps;
    logic [31:0] axis1_steps;
    logic [31:0] axis2_steps;
    logic [31:0] axis3_steps;
    logic [31:0] steps_done;
    logic [31:0] path_length;
    logic [31:0] cruise_speed;
    logic [31:0] accel_limit;
    logic [31:0] start_speed;
    logic [31:0] end_speed;
    logic        busy_req;
  } in_t;

  typedef struct packed {
    logic        skipped;
    logic        degenerate;
    logic [31:0] ramp_up_steps;
    logic [31:0] ramp_down_steps;
    logic [31:0] launch_rate;
    logic [31:0] cruise_rate;
    logic [31:0] finish_rate;
    logic [31:0] exit_speed_kept;
  } out_t;

  // restoring divider lane: remainder, dividend bits still to shift in, quotient
  typedef struct packed {
    logic        ovf;
    logic [40:0] rm;
    logic [32:0] sh;
    logic [32:0] q;
  } div_lane_t;

  // digit-by-digit square root lane, two radicand bits per step
  typedef struct packed {
    logic [63:0] v;
    logic [33:0] rm;
    logic [31:0] q;
  } sqrt_lane_t;

  typedef struct packed {
    logic             skip;
    logic             degen;
    logic [31:0]      total;
    logic [31:0]      len;
    logic [31:0]      done;
    logic [31:0]      rem;
    logic [31:0]      nn;
    logic [3:0][31:0] spd;   // cruise, accel, start, end
    logic [3:0][63:0] prod;
    div_lane_t [3:0]  dv;
    logic [31:0]      nom;
    logic [31:0]      acc;
    logic [31:0]      ir;
    logic [31:0]      fr;
    logic [63:0]      sq_i;
    logic [63:0]      sq_f;
    logic [63:0]      na;
    logic [63:0]      half;
    sqrt_lane_t [1:0] sq;
    logic [31:0]      top;
    logic             pos_up;
    logic             pos_dn;
    logic [63:0]      tt;
    logic [40:0]      den;
    logic [1:0][63:0] num;
    logic [31:0]      up;
    logic [31:0]      down;
    logic [1:0][63:0] ap;
  } ctx_t;

  localparam int STEPS     = 2;
  localparam int DIV_BITS  = 33;
  localparam int SQRT_BITS = 32;
  localparam int DIV_STG   = (DIV_BITS + STEPS - 1) / STEPS;
  localparam int SQRT_STG  = (SQRT_BITS + STEPS - 1) / STEPS;

  localparam int STG_MUL1  = 1;
  localparam int STG_DINIT = STG_MUL1 + 1;
  localparam int STG_DIV0  = STG_DINIT + 1;
  localparam int STG_RFIN  = STG_DIV0 + DIV_STG;
  localparam int STG_MUL2  = STG_RFIN + 1;
  localparam int STG_RADA  = STG_MUL2 + 1;
  localparam int STG_RADB  = STG_RADA + 1;
  localparam int STG_SQ1   = STG_RADB + 1;
  localparam int STG_TOP   = STG_SQ1 + SQRT_STG;
  localparam int STG_MUL3  = STG_TOP + 1;
  localparam int STG_NUM   = STG_MUL3 + 1;
  localparam int STG_RINIT = STG_NUM + 1;
  localparam int STG_RDIV0 = STG_RINIT + 1;
  localparam int STG_UP    = STG_RDIV0 + DIV_STG;
  localparam int STG_DOWN  = STG_UP + 1;
  localparam int STG_MUL4  = STG_DOWN + 1;
  localparam int STG_RAD2  = STG_MUL4 + 1;
  localparam int STG_SQ2   = STG_RAD2 + 1;
  localparam int NSTG      = STG_SQ2 + SQRT_STG;
  localparam int LATENCY   = NSTG + 1;

  function automatic div_lane_t div_step(input div_lane_t l, input logic [40:0] d);
    div_lane_t   o;
    logic [41:0] r2;
    logic [41:0] df;
    logic        ge;
    r2   = {l.rm, l.sh[32]};
    df   = r2 - {1'b0, d};
    ge   = (r2 >= {1'b0, d});
    o    = l;
    o.rm = ge ? df[40:0] : r2[40:0];
    o.sh = {l.sh[31:0], 1'b0};
    o.q  = {l.q[31:0], ge};
    return o;
  endfunction

  function automatic sqrt_lane_t sqrt_step(input sqrt_lane_t l);
    sqrt_lane_t  o;
    logic [35:0] r2;
    logic [35:0] tr;
    logic [35:0] df;
    logic        ge;
    r2   = {l.rm, l.v[63:62]};
    tr   = {2'b00, l.q, 2'b01};
    df   = r2 - tr;
    ge   = (r2 >= tr);
    o.rm = ge ? df[33:0] : r2[33:0];
    o.q  = {l.q[30:0], ge};
    o.v  = {l.v[61:0], 2'b00};
    return o;
  endfunction

  // Next value of pipeline stage idx from the register of stage idx-1.
  function automatic ctx_t trp_stage(input int unsigned idx, input ctx_t c);
    ctx_t             o;
    int unsigned      base;
    int unsigned      j;
    logic [31:0]      pl;
    logic [31:0]      lim;
    logic [40:0]      d;
    logic [33:0]      v34;
    logic [32:0]      v33;
    logic [63:0]      w;
    logic [64:0]      s65;
    logic [3:0][31:0] rt;
    o = c;
    if (idx == STG_MUL1) begin
      for (int k = 0; k < 4; k++) o.prod[k] = 64'(c.spd[k]) * 64'(c.total);
      pl    = (c.done > c.total) ? c.total : c.done;
      o.rem = c.total - pl;
      o.nn  = (c.total == pl) ? 32'd1 : c.total - pl;
    end else if (idx == STG_DINIT) begin
      // quotient would reach 2^24 -> rate saturates
      for (int k = 0; k < 4; k++) begin
        o.dv[k].ovf = (c.prod[k][63:24] >= 40'(c.len));
        o.dv[k].rm  = 41'(c.prod[k][63:24]);
        o.dv[k].sh  = {c.prod[k][23:0], 9'd0};
        o.dv[k].q   = '0;
      end
    end else if ((idx >= STG_DIV0 && idx < STG_DIV0 + DIV_STG) ||
                 (idx >= STG_RDIV0 && idx < STG_RDIV0 + DIV_STG)) begin
      base = (idx >= STG_RDIV0) ? STG_RDIV0 : STG_DIV0;
      d    = (idx >= STG_RDIV0) ? c.den : 41'(c.len);
      for (int s = 0; s < STEPS; s++) begin
        j = (idx - base) * STEPS + s;
        if (j < DIV_BITS) begin
          for (int k = 0; k < 4; k++) o.dv[k] = div_step(o.dv[k], d);
        end
      end
    end else if (idx == STG_RFIN) begin
      // quotient carries one extra bit: +1 then drop it rounds half up
      for (int k = 0; k < 4; k++) begin
        v34   = {1'b0, c.dv[k].q} + 34'd1;
        v33   = v34[33:1];
        rt[k] = (c.dv[k].ovf || v33[32]) ? 32'hFFFF_FFFF : v33[31:0];
      end
      o.nom = rt[0];
      o.acc = rt[1];
      o.ir  = rt[2];
      o.fr  = rt[3];
    end else if (idx == STG_MUL2) begin
      o.sq_i = 64'(c.ir) * 64'(c.ir);
      o.sq_f = 64'(c.fr) * 64'(c.fr);
      o.na   = 64'(c.nn) * 64'(c.acc);
    end else if (idx == STG_RADA) begin
      o.na   = (c.na[63:56] != 8'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : {c.na[55:0], 8'd0};
      o.half = (c.sq_i >> 1) + (c.sq_f >> 1) + 64'(c.sq_i[0] & c.sq_f[0]);
    end else if (idx == STG_RADB) begin
      s65        = {1'b0, c.na} + {1'b0, c.half};
      o.sq[0].v  = s65[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s65[63:0];
      o.sq[0].rm = '0;
      o.sq[0].q  = '0;
    end else if ((idx >= STG_SQ1 && idx < STG_SQ1 + SQRT_STG) ||
                 (idx >= STG_SQ2 && idx < STG_SQ2 + SQRT_STG)) begin
      base = (idx >= STG_SQ2) ? STG_SQ2 : STG_SQ1;
      for (int s = 0; s < STEPS; s++) begin
        j = (idx - base) * STEPS + s;
        if (j < SQRT_BITS) begin
          for (int k = 0; k < 2; k++) o.sq[k] = sqrt_step(o.sq[k]);
        end
      end
    end else if (idx == STG_TOP) begin
      o.top    = (c.sq[0].q < c.nom) ? c.sq[0].q : c.nom;
      o.pos_up = (((c.sq[0].q < c.nom) ? c.sq[0].q : c.nom) > c.ir);
      o.pos_dn = (((c.sq[0].q < c.nom) ? c.sq[0].q : c.nom) > c.fr);
    end else if (idx == STG_MUL3) begin
      o.tt  = 64'(c.top) * 64'(c.top);
      o.den = {c.acc, 9'd0};
    end else if (idx == STG_NUM) begin
      o.num[0] = c.pos_up ? c.tt - c.sq_i : 64'd0;
      o.num[1] = c.pos_dn ? c.tt - c.sq_f : 64'd0;
    end else if (idx == STG_RINIT) begin
      // doubled numerator; zero den always flags overflow (unbounded ramp)
      for (int k = 0; k < 2; k++) begin
        o.dv[k].ovf = ({9'd0, c.num[k][63:32]} >= c.den);
        o.dv[k].rm  = 41'(c.num[k][63:32]);
        o.dv[k].sh  = {c.num[k][31:0], 1'b0};
        o.dv[k].q   = '0;
      end
    end else if (idx == STG_UP) begin
      v34 = {1'b0, c.dv[0].q} + 34'd1;
      v33 = v34[33:1];
      if (!c.pos_up) o.up = '0;
      else if (c.dv[0].ovf || v33 > {1'b0, c.rem}) o.up = c.rem;
      else o.up = v33[31:0];
    end else if (idx == STG_DOWN) begin
      lim = c.rem - c.up;
      v34 = {1'b0, c.dv[1].q} + 34'd1;
      v33 = v34[33:1];
      if (!c.pos_dn) o.down = '0;
      else if (c.dv[1].ovf || v33 > {1'b0, lim}) o.down = lim;
      else o.down = v33[31:0];
    end else if (idx == STG_MUL4) begin
      o.ap[0] = 64'(c.acc) * 64'(c.up);
      o.ap[1] = 64'(c.acc) * 64'(c.down);
    end else if (idx == STG_RAD2) begin
      for (int k = 0; k < 2; k++) begin
        w          = (c.ap[k][63:55] != 9'd0) ? 64'hFFFF_FFFF_FFFF_FFFF
                                              : {c.ap[k][54:0], 9'd0};
        s65        = {1'b0, w} + {1'b0, (k == 0) ? c.sq_i : c.sq_f};
        o.sq[k].v  = s65[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s65[63:0];
        o.sq[k].rm = '0;
        o.sq[k].q  = '0;
      end
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== sv/trapezoid_ramp_profile_core.sv =====
// Trapezoid ramp profile core: fully pipelined profile computation per motion block.
// Depends on trp_pkg for payload types, the stage map and the stage datapath.
//
// Usage:
//   Input: drive in_data and pulse start; a transaction is taken at every rising
//   edge with start high and busy low. busy is high only while rst_n is low, so
//   one block can enter per clock, back to back, with any gaps.
//   Output: out_valid is high for exactly one cycle with out_data, in input order.
//   Each block passes through the ctx_r stage registers, then the output register;
//   throughput is one block per cycle. The depth is set by the four parallel
//   33-step rate dividers, the peak-rate square root, the two ramp-length
//   dividers and the two reached-peak square roots, each a chain of pipeline
//   stages doing two iterations per stage.
//   The result receiver cannot stall, so nothing here holds back.
//   Reset (rst_n low, synchronous) clears all stage valid bits; blocks in flight
//   are dropped and no result follows for them.
`default_nettype none

module trapezoid_ramp_profile_core #(
  parameter int ACTUATORS = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  trp_pkg::in_t  in_data,
  output logic          out_valid,
  output trp_pkg::out_t out_data
);
  import trp_pkg::*;

  localparam int AXES = (ACTUATORS < 4) ? ACTUATORS : 4;

  logic [3:0][31:0] axes;
  ctx_t             cap_c;
  ctx_t             ctx_nxt [NSTG];
  ctx_t             ctx_r   [NSTG];
  logic [NSTG-1:0]  vld_nxt;
  logic [NSTG-1:0]  vld_r;
  logic             out_valid_nxt;
  logic             out_valid_r;
  out_t             out_data_nxt;
  out_t             out_data_r;
  ctx_t             last_c;
  logic [31:0]      pk;

  assign busy = ~rst_n;
  assign axes = {in_data.axis3_steps, in_data.axis2_steps,
                 in_data.axis1_steps, in_data.axis0_steps};

  // capture stage: longest axis and the degenerate/skip flags
  always_comb begin
    cap_c = '0;
    for (int k = 0; k < AXES; k++) begin
      if (axes[k] > cap_c.total) cap_c.total = axes[k];
    end
    cap_c.skip  = in_data.busy_req;
    cap_c.len   = in_data.path_length;
    cap_c.done  = in_data.steps_done;
    cap_c.spd   = {in_data.end_speed, in_data.start_speed,
                   in_data.accel_limit, in_data.cruise_speed};
    cap_c.degen = (in_data.path_length == 32'd0) || (cap_c.total == 32'd0);
  end

  assign ctx_nxt[0] = cap_c;

  for (genvar g = 1; g < NSTG; g++) begin : g_stage
    assign ctx_nxt[g] = trp_stage(g, ctx_r[g-1]);
  end

  assign vld_nxt = {vld_r[NSTG-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctx_r <= ctx_nxt;
  end

  // output stage: plateau lowered to what the clamped legs reach
  always_comb begin
    last_c = ctx_r[NSTG-1];
    pk     = last_c.top;
    if (last_c.up != 32'd0 && last_c.sq[0].q < pk) pk = last_c.sq[0].q;
    if (last_c.down != 32'd0 && last_c.sq[1].q < pk) pk = last_c.sq[1].q;
    out_data_nxt = '0;
    if (last_c.skip) begin
      out_data_nxt.skipped = 1'b1;
    end else begin
      out_data_nxt.exit_speed_kept = last_c.spd[3];
      if (last_c.degen) begin
        out_data_nxt.degenerate = 1'b1;
      end else begin
        out_data_nxt.ramp_up_steps   = last_c.up;
        out_data_nxt.ramp_down_steps = last_c.down;
        out_data_nxt.launch_rate     = last_c.ir;
        out_data_nxt.cruise_rate     = pk;
        out_data_nxt.finish_rate     = last_c.fr;
      end
    end
    out_valid_nxt = vld_r[NSTG-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== sv/trp_checker.sv =====
// Port-level checker for the trapezoid ramp profile core, bound to the top level.
// Depends on trp_pkg and trapezoid_ramp_profile_core_assert.svh.
`default_nettype none
`include "trapezoid_ramp_profile_core_assert.svh"

module trp_checker (
  input wire           clk,
  input wire           rst_n,
  input wire           start,
  input wire           busy,
  input trp_pkg::in_t  in_data,
  input wire           out_valid,
  input trp_pkg::out_t out_data
);
  import trp_pkg::*;

  // every result traces back to an accepted transaction, and every transaction yields a result
  `TRP_ASSERT_IMP(a_out_has_in, clk, rst_n, out_valid, $past(start && !busy && rst_n, LATENCY), "result without transaction")
  `TRP_ASSERT_DLY(a_in_gets_out, clk, rst_n, start && !busy, LATENCY, out_valid, "transaction lost")
  `TRP_ASSERT_IMP(a_skip_follows, clk, rst_n, out_valid, out_data.skipped == $past(in_data.busy_req, LATENCY), "skip flag mismatch")
  `TRP_ASSERT_IMP(a_degen_exit, clk, rst_n, out_valid && out_data.degenerate, out_data.exit_speed_kept == $past(in_data.end_speed, LATENCY), "exit speed lost")

endmodule

bind trapezoid_ramp_profile_core trp_checker u_trp_checker (.*);

`default_nettype wire
